>>> rtl/core/evad_pkg.sv
package evad_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SQ_W       = 31;
    localparam int THR_W      = 31;
    localparam int LIMIT_W    = 24;
    localparam int CNT_W      = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};
    localparam logic [THR_W-1:0]   THR_RESET   = 31'd107374;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd32000;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT = 8'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_end;
    } t_in_item;

    typedef struct packed {
        logic voice_active;
        logic frame_loud;
    } t_out_item;

endpackage

>>> rtl/core/energy_voice_activity_detector.sv
// Energy voice activity detector with hangover.
// The input channel carries one signed audio sample per request, with a flag
// that marks the last sample of a frame. A frame also ends by itself once it
// holds MAX_FRAME samples. Exactly one result request leaves the block for
// each frame: the frame_loud flag and the voice_active decision.
// The configuration channel writes the mean-square threshold (index 0) and
// the silence limit in samples (index 1). It is always ready and should be
// used only while no frame is in flight.
// Throughput is one sample per cycle while the output queue is not full;
// the sample multiplier, the frame accumulator and the decision logic each
// sit in their own pipeline stage. The last sample of a frame passes the
// stage 1, 2 and 3 registers, then its result enters the output queue.
// A two-entry output queue (output register plus skid register) lets the
// pipeline keep running while one result waits. When both entries hold
// results, the input stops taking samples until the receiver drains one.
// Reset clears the frame accumulator, the silent-frame count, the voice
// flag and all pipeline valid bits, and loads the default register values.
module energy_voice_activity_detector #(
    parameter int MAX_FRAME = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  evad_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output evad_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [evad_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [evad_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import evad_pkg::*;

    localparam int LEN_W  = $clog2(MAX_FRAME + 1);
    localparam int SUM_W  = SQ_W + $clog2(MAX_FRAME);
    localparam int THRN_W = THR_W + LEN_W;
    localparam int CP_W   = CNT_W + LEN_W;

    // Configuration registers.
    logic [THR_W-1:0]   r_thr;
    logic [LIMIT_W-1:0] r_limit;

    // Stage 1: registered input sample.
    logic                       r1_v;
    logic signed [SAMPLE_W-1:0] r1_sample;
    logic                       r1_end;

    // Stage 2: squared magnitude.
    logic            r2_v;
    logic [SQ_W-1:0] r2_sq;
    logic            r2_end;

    // Frame accumulator state.
    logic [SUM_W-1:0] r_sum;
    logic [LEN_W-1:0] r_len;

    // Stage 3: finished frame totals.
    logic              r3_v;
    logic [SUM_W-1:0]  r3_sum;
    logic [LEN_W-1:0]  r3_len;
    logic [THRN_W-1:0] r3_thrn;

    // Hangover state.
    logic [CNT_W-1:0] r_count;
    logic             r_voice;
    logic [CNT_W-1:0] n_count;
    logic             n_voice;

    // Output queue.
    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;
    logic      n_out_valid;
    t_out_item n_out;
    logic      n_skid_valid;
    t_out_item n_skid;

    logic                en;
    logic [SAMPLE_W:0]   mag_ext;
    logic [SAMPLE_W:0]   mag;
    logic [2*SAMPLE_W+1:0] sq_full;
    logic [SUM_W-1:0]    sum_new;
    logic [LEN_W-1:0]    len_new;
    logic                end_now;
    logic                loud;
    logic [CNT_W-1:0]    cnt_inc;
    logic [CP_W-1:0]     cnt_prod;
    logic                timeout;
    t_out_item           res;
    logic                new_res;
    logic                out_take;

    // The pipeline moves whenever the skid entry is free, so at most one
    // new result can land while the output register is still occupied.
    assign en          = !r_skid_valid;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_THRESHOLD: begin
                    r_thr <= i_cfg_data[THR_W-1:0];
                end
                REG_SILENCE_LIMIT: begin
                    r_limit <= i_cfg_data[LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stage 1 to stage 2: square of the sample magnitude. The most negative
    // sample gives a magnitude of 32768, exactly a quarter of the 17-bit range.
    assign mag_ext = {r1_sample[SAMPLE_W-1], r1_sample};
    assign mag     = mag_ext[SAMPLE_W] ? ((SAMPLE_W+1)'(0) - mag_ext) : mag_ext;
    assign sq_full = (2*SAMPLE_W+2)'(mag) * (2*SAMPLE_W+2)'(mag);

    // Stage 2 to stage 3: accumulation and frame end detection.
    assign sum_new = r_sum + SUM_W'(r2_sq);
    assign len_new = r_len + LEN_W'(1);
    assign end_now = r2_end || (len_new >= LEN_W'(MAX_FRAME));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r_sum <= '0;
            r_len <= '0;
        end else if (en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v && end_now;
            if (r2_v) begin
                if (end_now) begin
                    r_sum <= '0;
                    r_len <= '0;
                end else begin
                    r_sum <= sum_new;
                    r_len <= len_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sample <= i_in_data.sample;
            r1_end    <= i_in_data.frame_end;
            r2_sq     <= sq_full[SQ_W-1:0];
            r2_end    <= r1_end;
            r3_sum    <= sum_new;
            r3_len    <= len_new;
            r3_thrn   <= THRN_W'(r_thr) * THRN_W'(len_new);
        end
    end

    // Stage 3: loudness decision against threshold times frame length, then
    // the silent-frame count and its timeout against the sample limit.
    always_comb begin
        loud     = THRN_W'(r3_sum) > r3_thrn;
        cnt_inc  = (r_count == CNT_MAX) ? r_count : (r_count + CNT_W'(1));
        cnt_prod = CP_W'(cnt_inc) * CP_W'(r3_len);
        timeout  = cnt_prod >= CP_W'(r_limit);
        n_count  = r_count;
        n_voice  = r_voice;
        res.frame_loud   = loud;
        res.voice_active = 1'b0;
        if (loud) begin
            n_count          = '0;
            n_voice          = 1'b1;
            res.voice_active = 1'b1;
        end else if (timeout) begin
            n_count          = '0;
            n_voice          = 1'b0;
            res.voice_active = 1'b0;
        end else begin
            n_count          = cnt_inc;
            res.voice_active = r_voice;
        end
    end

    assign new_res  = en && r3_v;
    assign out_take = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_voice <= 1'b0;
        end else if (new_res) begin
            r_count <= n_count;
            r_voice <= n_voice;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (out_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (new_res) begin
            if (!r_out_valid || out_take) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len < LEN_W'(MAX_FRAME))
        else $error("frame length reached the maximum without closing the frame");

    a_loud_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_loud) |-> o_out_data.voice_active)
        else $error("loud frame reported without voice");

    a_loud_sets_voice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (new_res && loud) |=> (r_voice && (r_count == '0)))
        else $error("loud frame did not set voice and clear the count");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_ready) |=> (r_skid_valid && $stable(r_count)))
        else $error("pipeline moved while the output queue was full");
`endif

endmodule
